// ----- hdl/spfa_pkg.sv -----
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared types and constants of the queue-based shortest path engine.
// ----------------------------------------------------------------------------
package spfa_pkg;

	localparam int unsigned MaxNodes = 1024;
	localparam int unsigned MaxEdges = 4096;
	localparam int unsigned NodeW    = 10;
	localparam int unsigned EdgeW    = 12;
	localparam int unsigned LinkW    = 13;
	localparam int unsigned CostW    = 16;
	localparam int unsigned DistW    = 32;

	localparam logic [LinkW-1:0] ListEmpty = LinkW'(MaxEdges);
	localparam logic [DistW-1:0] DistInf   = '1;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_RUN   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic {
		REG_SOURCE = 1'b0,
		REG_TARGET = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [NodeW-1:0] from_node;
		logic [NodeW-1:0] to_node;
		logic [CostW-1:0] edge_cost;
	} item_t;

	typedef struct packed {
		logic [DistW-1:0] distance;
		logic             reachable;
		logic             edge_overflow;
	} result_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clr_sweep;   // write head[idx]=empty and clear mark[idx]
		logic init_sweep;  // write dist[idx]=inf and mark[idx]=0
		logic graph_clear; // reset count and overflow
		logic add_edge;    // perform add of latched item
		logic seed;        // push source, dist=0
		logic pop;         // pop fifo, read head and dist of node
		logic load_head;   // latch head/dist of popped node
		logic edge_rd;     // read edge entry e
		logic edge_cmp;    // read dist of destination, compute candidate
		logic edge_upd;    // compare, update, push, advance e
		logic tgt_rd;      // read target distance
		logic emit;        // drive result
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic fifo_empty;
		logic edge_valid;
	} stat_t;

endpackage

// ----- hdl/spfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// spfa_ctrl
// Sequencer for clear, add and run transactions.
// ----------------------------------------------------------------------------
module spfa_ctrl
	import spfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_RESET, ST_IDLE, ST_CLEAR, ST_ADD, ST_INIT, ST_SEED, ST_POP, ST_HEAD,
		ST_ERD, ST_ECMP, ST_EUPD, ST_TRD, ST_EMIT
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else begin
			unique case (state_q)
				ST_RESET: if (stat.idx_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (start) begin
						unique case (action_t'(item.action))
							ACT_CLEAR: state_q <= ST_CLEAR;
							ACT_ADD:   state_q <= ST_ADD;
							ACT_RUN:   state_q <= ST_INIT;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: if (stat.idx_last) state_q <= ST_IDLE;
				ST_ADD:   state_q <= ST_IDLE;
				ST_INIT:  if (stat.idx_last) state_q <= ST_SEED;
				ST_SEED:  state_q <= ST_POP;
				ST_POP:   state_q <= stat.fifo_empty ? ST_TRD : ST_HEAD;
				ST_HEAD:  state_q <= ST_ERD;
				ST_ERD:   state_q <= stat.edge_valid ? ST_ECMP : ST_POP;
				ST_ECMP:  state_q <= ST_EUPD;
				ST_EUPD:  state_q <= ST_ERD;
				ST_TRD:   state_q <= ST_EMIT;
				ST_EMIT:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_RESET: cmd.clr_sweep = 1'b1;
			ST_IDLE: begin
				cmd.graph_clear = start && (action_t'(item.action) == ACT_CLEAR);
			end
			ST_CLEAR: cmd.clr_sweep = 1'b1;
			ST_ADD:   cmd.add_edge = 1'b1;
			ST_INIT:  cmd.init_sweep = 1'b1;
			ST_SEED:  cmd.seed = 1'b1;
			ST_POP:   cmd.pop = !stat.fifo_empty;
			ST_HEAD:  cmd.load_head = 1'b1;
			ST_ERD:   cmd.edge_rd = 1'b1;
			ST_ECMP:  cmd.edge_cmp = 1'b1;
			ST_EUPD:  cmd.edge_upd = 1'b1;
			ST_TRD:   cmd.tgt_rd = 1'b1;
			ST_EMIT:  cmd.emit = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

// ----- hdl/spfa_dpath.sv -----
// ----------------------------------------------------------------------------
// spfa_dpath
// Edge store, distance and mark memories, work queue and relaxation logic.
// ----------------------------------------------------------------------------
module spfa_dpath
	import spfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [NodeW-1:0] cfg_data,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic             result_valid,
	output result_t          result
);

	// memories
	logic [LinkW-1:0] head_mem [MaxNodes];
	logic [NodeW-1:0] dest_mem [MaxEdges];
	logic [CostW-1:0] wt_mem   [MaxEdges];
	logic [LinkW-1:0] link_mem [MaxEdges];
	logic [DistW-1:0] dist_mem [MaxNodes];
	logic             mark_mem [MaxNodes];
	logic [NodeW-1:0] fifo_mem [MaxNodes];

	logic [NodeW-1:0] src_q, tgt_q, idx_q;
	item_t            item_q;
	logic [LinkW-1:0] count_q;
	logic             ovf_q;
	logic [NodeW-1:0] rd_q, wr_q;
	logic [NodeW:0]   cnt_q;
	logic [NodeW-1:0] u_q, v_q;
	logic [LinkW-1:0] e_q, head_rd_q, link_rd_q;
	logic [DistW-1:0] du_q, dist_rd_q;
	logic [CostW-1:0] w_q;
	logic [DistW:0]   sum;
	logic [DistW-1:0] nd_q;
	logic             mark_rd_q;
	logic [NodeW-1:0] fifo_rd_q;
	logic             relax;
	logic             push;

	assign stat.idx_last   = (idx_q == NodeW'(MaxNodes - 1));
	assign stat.fifo_empty = (cnt_q == '0);
	assign stat.edge_valid = (e_q < count_q);

	// config registers and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= NodeW'(1);
			tgt_q   <= NodeW'(1);
			idx_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			rd_q    <= '0;
			wr_q    <= '0;
			cnt_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_SOURCE) src_q <= cfg_data;
				else tgt_q <= cfg_data;
			end
			if (cmd.clr_sweep || cmd.init_sweep) idx_q <= idx_q + NodeW'(1);
			if (cmd.graph_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.add_edge) begin
				if (count_q == ListEmpty) ovf_q <= 1'b1;
				else count_q <= count_q + LinkW'(1);
			end
			if (cmd.seed) begin
				rd_q  <= '0;
				wr_q  <= NodeW'(1);
				cnt_q <= (NodeW + 1)'(1);
			end
			if (cmd.pop) begin
				rd_q <= rd_q + NodeW'(1);
			end
			if (cmd.edge_upd && push) wr_q <= wr_q + NodeW'(1);
			if (cmd.pop && !(cmd.edge_upd && push)) cnt_q <= cnt_q - (NodeW + 1)'(1);
			else if (!cmd.pop && cmd.edge_upd && push) cnt_q <= cnt_q + (NodeW + 1)'(1);
		end
	end

	// latch item on acceptance
	always_ff @(posedge clk) begin
		if (start && !busy) item_q <= item;
	end

	// head list and mark memory, idle reads the head of the incoming edge source
	always_ff @(posedge clk) begin
		if (cmd.clr_sweep) head_mem[idx_q] <= ListEmpty;
		else if (cmd.add_edge && count_q != ListEmpty)
			head_mem[item_q.from_node] <= count_q;
		head_rd_q <= head_mem[busy ? fifo_rd_q : item.from_node];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_sweep || cmd.init_sweep) mark_mem[idx_q] <= 1'b0;
		else if (cmd.seed) mark_mem[src_q] <= 1'b1;
		else if (cmd.load_head) mark_mem[u_q] <= 1'b0;
		else if (cmd.edge_upd && push) mark_mem[v_q] <= 1'b1;
		mark_rd_q <= mark_mem[v_q];
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.add_edge && count_q != ListEmpty) begin
			dest_mem[count_q[EdgeW-1:0]] <= item_q.to_node;
			wt_mem[count_q[EdgeW-1:0]]   <= item_q.edge_cost;
			link_mem[count_q[EdgeW-1:0]] <= head_rd_q;
		end
		v_q       <= dest_mem[e_q[EdgeW-1:0]];
		w_q       <= wt_mem[e_q[EdgeW-1:0]];
		link_rd_q <= link_mem[e_q[EdgeW-1:0]];
	end

	// work queue, the seeded source bypasses the memory read
	always_ff @(posedge clk) begin
		if (cmd.seed) fifo_mem['0] <= src_q;
		else if (cmd.edge_upd && push) fifo_mem[wr_q] <= v_q;
		fifo_rd_q <= cmd.seed ? src_q : fifo_mem[rd_q];
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (cmd.init_sweep) dist_mem[idx_q] <= DistInf;
		else if (cmd.seed) dist_mem[src_q] <= '0;
		else if (cmd.edge_upd && relax) dist_mem[v_q] <= nd_q;
		dist_rd_q <= dist_mem[cmd.tgt_rd ? tgt_q : (cmd.edge_cmp ? v_q : fifo_rd_q)];
	end

	// walk state: u, e and candidate distance
	assign sum   = {1'b0, du_q} + {{(DistW + 1 - CostW){1'b0}}, w_q};
	assign relax = (dist_rd_q > nd_q);
	assign push  = relax && !mark_rd_q && (cnt_q != (NodeW + 1)'(MaxNodes));

	always_ff @(posedge clk) begin
		if (cmd.pop) u_q <= fifo_rd_q;
		if (cmd.load_head) begin
			e_q  <= head_rd_q;
			du_q <= dist_rd_q;
		end
		if (cmd.edge_cmp) nd_q <= sum[DistW] ? DistInf : sum[DistW-1:0];
		if (cmd.edge_upd) e_q <= link_rd_q;
	end

	// result
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.distance      <= dist_rd_q;
			result.reachable     <= (dist_rd_q != DistInf);
			result.edge_overflow <= ovf_q;
		end
	end

endmodule

// ----- hdl/spfa_shortest_path_engine.sv -----
// After acceptance a clear sweeps the heads empty, an add stores one edge, and a run
// inits the distances, seeds the source, walks each popped node's edges, then emits.
// Throughput: one transaction at a time; busy stays high until it completes.
// The result strobe is high one cycle and cannot be stalled.
// On reset the adjacency heads are swept empty, busy high meanwhile.
// ----------------------------------------------------------------------------
// spfa_shortest_path_engine
// Queue-based Bellman-Ford shortest path engine over stored adjacency lists.
// ----------------------------------------------------------------------------
module spfa_shortest_path_engine
	import spfa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  item_t                  item,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [NodeW-1:0]       cfg_data,
	output logic                   result_valid,
	output result_t                result
);

	cmd_t  cmd;
	stat_t stat;

	spfa_ctrl u_ctrl (
		.clk, .arst_n, .start, .item, .stat, .busy, .cmd
	);

	spfa_dpath u_dpath (
		.clk, .arst_n, .start, .busy, .item, .cfg_we, .cfg_index, .cfg_data,
		.cmd, .stat, .result_valid, .result
	);

endmodule

// ----- hdl/spfa_checker.sv -----
// ----------------------------------------------------------------------------
// spfa_checker
// Port-level checks of the shortest path engine.
// ----------------------------------------------------------------------------
module spfa_checker
	import spfa_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    result_valid,
	input result_t result
);

	// a result strobe lasts one cycle
	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double strobe");

	// results only come while a transaction is in flight
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("stray result");

	// reachable matches a finite distance
	a_reach: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.reachable == (result.distance != DistInf)))
		else $error("reachable mismatch");

	// accepting a transaction with a defined action raises busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action_t'(item.action) != ACT_NONE)) |=> busy)
		else $error("accept without busy");

endmodule

bind spfa_shortest_path_engine spfa_checker u_chk (
	.clk, .arst_n, .start, .busy, .item, .result_valid, .result
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the shortest path engine against a behavioral path solver kept in
// the bench: edges are loaded, cleared and overflowed, runs are compared.
// ----------------------------------------------------------------------------
module tb;
	import spfa_pkg::*;

	localparam int unsigned StallLimit = 200000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             cfg_we;
	logic             cfg_index;
	logic [NodeW-1:0] cfg_data;
	logic             result_valid;
	result_t          result;

	// solver copy of the graph and registers
	logic [NodeW-1:0] src_reg;
	logic [NodeW-1:0] tgt_reg;
	logic [LinkW-1:0] head_of [MaxNodes];
	logic [NodeW-1:0] dest_of [MaxEdges];
	logic [CostW-1:0] cost_of [MaxEdges];
	logic [LinkW-1:0] link_of [MaxEdges];
	int unsigned      stored_edges;
	logic             dropped_edge;

	result_t     pending_results[$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	bit          no_gaps;
	int unsigned items_sent;

	spfa_shortest_path_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// empty graph
	function automatic void wipe_graph();
		for (int i = 0; i < MaxNodes; i++) head_of[i] = ListEmpty;
		stored_edges = 0;
		dropped_edge = 1'b0;
	endfunction

	// relax edges from a node queue until it drains
	function automatic result_t solve_paths();
		logic [DistW-1:0] node_dist [MaxNodes];
		bit               queued [MaxNodes];
		int unsigned      work[$];
		int unsigned      u;
		int unsigned      e;
		logic [DistW:0]   sum;
		logic [DistW-1:0] cand;
		result_t          r;
		for (int i = 0; i < MaxNodes; i++) begin
			node_dist[i] = DistInf;
			queued[i] = 1'b0;
		end
		node_dist[src_reg] = '0;
		work.push_back(src_reg);
		queued[src_reg] = 1'b1;
		while (work.size() != 0) begin
			u = work.pop_front();
			queued[u] = 1'b0;
			e = head_of[u];
			while (e < stored_edges) begin
				sum = {1'b0, node_dist[u]} + cost_of[e];
				cand = sum[DistW] ? DistInf : sum[DistW-1:0];
				if (node_dist[dest_of[e]] > cand) begin
					node_dist[dest_of[e]] = cand;
					if (!queued[dest_of[e]] && work.size() < MaxNodes) begin
						work.push_back(dest_of[e]);
						queued[dest_of[e]] = 1'b1;
					end
				end
				e = link_of[e];
			end
		end
		r.distance = node_dist[tgt_reg];
		r.reachable = (node_dist[tgt_reg] != DistInf);
		r.edge_overflow = dropped_edge;
		return r;
	endfunction

	// update the solver with one accepted transaction
	function automatic void apply_item(item_t it);
		case (action_t'(it.action))
			ACT_CLEAR: wipe_graph();
			ACT_ADD: begin
				if (stored_edges >= MaxEdges) begin
					dropped_edge = 1'b1;
				end else begin
					dest_of[stored_edges] = it.to_node;
					cost_of[stored_edges] = it.edge_cost;
					link_of[stored_edges] = head_of[it.from_node];
					head_of[it.from_node] = LinkW'(stored_edges);
					stored_edges++;
				end
			end
			ACT_RUN: pending_results.push_back(solve_paths());
			default: ;
		endcase
	endfunction

	// send one transaction, start stays high when the next follows at once
	task automatic send_item(item_t it);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_item(it);
		items_sent++;
	endtask

	task automatic send_fields(action_t act, int unsigned f, int unsigned t, int unsigned c);
		item_t it;
		it.action = act;
		it.from_node = NodeW'(f);
		it.to_node = NodeW'(t);
		it.edge_cost = CostW'(c);
		send_item(it);
	endtask

	// drain results and let the block go idle, then write a register
	task automatic write_reg(reg_idx_t idx, int unsigned val);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= NodeW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOURCE) src_reg = NodeW'(val);
		else tgt_reg = NodeW'(val);
	endtask

	task automatic set_path(int unsigned s, int unsigned t);
		write_reg(REG_SOURCE, s);
		write_reg(REG_TARGET, t);
	endtask

	// source and target both at reset value on an empty graph
	task automatic test_reset_defaults();
		send_fields(ACT_RUN, 0, 0, 0);
		send_fields(ACT_NONE, 1023, 1023, 65535);
		send_fields(ACT_RUN, 1023, 1023, 65535);
	endtask

	// extremes of the fields and every action on a hand-made graph
	task automatic test_directed_graph();
		send_fields(ACT_CLEAR, 1023, 1023, 65535);
		send_fields(ACT_ADD, 0, 1023, 65535);
		send_fields(ACT_ADD, 1023, 0, 0);
		send_fields(ACT_ADD, 0, 1, 7);
		send_fields(ACT_ADD, 1, 1023, 3);
		send_fields(ACT_ADD, 1, 1, 0);
		send_fields(ACT_NONE, 0, 0, 0);
		set_path(0, 1023);
		send_fields(ACT_RUN, 0, 0, 0);
		set_path(1023, 0);
		send_fields(ACT_RUN, 0, 0, 0);
		set_path(1023, 512);
		send_fields(ACT_RUN, 0, 0, 0);
		send_fields(ACT_CLEAR, 0, 0, 0);
		set_path(0, 0);
		send_fields(ACT_RUN, 0, 0, 0);
	endtask

	// fill the edge store, drop a few more, then clear the flag
	task automatic test_store_full();
		send_fields(ACT_CLEAR, 0, 0, 0);
		no_gaps = 1'b1;
		for (int i = 0; i < MaxEdges + 3; i++)
			send_fields(ACT_ADD, 1000, (i % 3 == 0) ? 1001 : 1002, $urandom_range(65535));
		no_gaps = 1'b0;
		set_path(1000, 1001);
		send_fields(ACT_RUN, 0, 0, 0);
		set_path(5, 5);
		send_fields(ACT_RUN, 0, 0, 0);
		send_fields(ACT_CLEAR, 0, 0, 0);
		send_fields(ACT_RUN, 0, 0, 0);
	endtask

	function automatic int unsigned pick_node();
		if ($urandom_range(7) == 0) return $urandom_range(1023);
		return $urandom_range(7);
	endfunction

	// well-formed load and run sequences with random content and noise
	task automatic test_random_graphs();
		int unsigned n;
		int unsigned goal;
		goal = items_sent + 900;
		while (items_sent < goal) begin
			no_gaps = ($urandom_range(3) == 0);
			if ($urandom_range(9) < 7) send_fields(ACT_CLEAR, $urandom, $urandom, $urandom);
			n = $urandom_range(12, 1);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(15) == 0)
					send_fields(ACT_NONE, $urandom, $urandom, $urandom);
				else
					send_fields(ACT_ADD, pick_node(), pick_node(), $urandom_range(65535));
			end
			if ($urandom_range(1) == 0) begin
				case ($urandom_range(5))
					0: set_path(0, 1023);
					1: set_path(1023, 0);
					default: set_path(pick_node(), pick_node());
				endcase
			end
			n = $urandom_range(2, 1);
			for (int i = 0; i < n; i++) send_fields(ACT_RUN, $urandom, $urandom, $urandom);
		end
		no_gaps = 1'b0;
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result dist=%0h reach=%0b ovf=%0b",
						result.distance, result.reachable, result.edge_overflow);
			end else begin
				want = pending_results.pop_front();
				if (result.distance !== want.distance || result.reachable !== want.reachable
						|| result.edge_overflow !== want.edge_overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp dist=%0h reach=%0b ovf=%0b got dist=%0h reach=%0b ovf=%0b",
							want.distance, want.reachable, want.edge_overflow,
							result.distance, result.reachable, result.edge_overflow);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		items_sent = 0;
		src_reg = 1;
		tgt_reg = 1;
		wipe_graph();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_graph();
		test_store_full();
		test_random_graphs();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
